// ===== hw/rtl/ipqm_pkg.sv =====
// Shared types, constants and the calculation sequence of the image pair quality map.
`default_nettype none
package ipqm_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int WIN_SIZE   = 5;
   localparam int WIN_CENTRE = 2;
   localparam int LINE_DEPTH = WIN_SIZE * MAX_WIDTH;
   localparam int COL_W      = 9;
   localparam int ROW_W      = 10;
   localparam int SLOT_W     = 3;
   localparam int ADDR_W     = 12;
   localparam int SUM_W      = 13;
   localparam int ACC_W      = 34;
   localparam int CFG_W      = 10;
   localparam int IDX_W      = 3;

   // 2601 * 625 and 23409 * 625: the stabilizing terms at window scale
   localparam logic [23:0] C1_TERM = 24'd1625625;
   localparam logic [23:0] C2_TERM = 24'd14630625;

   localparam logic [0:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [0:0] CSR_FRAME_HEIGHT = 1'd1;

   typedef logic [4:0] op_type;

   localparam op_type OP_NOP    = 5'd0;
   localparam op_type OP_ACCEPT = 5'd1;
   localparam op_type OP_READ   = 5'd2;
   localparam op_type OP_DEV    = 5'd3;
   localparam op_type OP_AB     = 5'd4;
   localparam op_type OP_SQA    = 5'd5;
   localparam op_type OP_SQB    = 5'd6;
   localparam op_type OP_DAB    = 5'd7;
   localparam op_type OP_DQA    = 5'd8;
   localparam op_type OP_DQB    = 5'd9;
   localparam op_type OP_P1     = 5'd10;
   localparam op_type OP_P2E    = 5'd11;
   localparam op_type OP_P2     = 5'd12;
   localparam op_type OP_P3     = 5'd13;
   localparam op_type OP_P4     = 5'd14;
   localparam op_type OP_DENLO  = 5'd15;
   localparam op_type OP_DENHI  = 5'd16;
   localparam op_type OP_CRLO   = 5'd17;
   localparam op_type OP_CRHI   = 5'd18;
   localparam op_type OP_NUM    = 5'd19;
   localparam op_type OP_SCALE  = 5'd20;
   localparam op_type OP_DIV    = 5'd21;
   localparam op_type OP_LOAD   = 5'd22;

   localparam int CALC_STEPS = 26;
   localparam int DIV_FIRST  = 18;

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] win_row;
      logic [IDX_W-1:0] win_col;
      logic [2:0]       div_shift;
   } cmd_type;

   typedef struct packed {
      logic window_ok;
      logic out_free;
   } status_type;

   function automatic cmd_type calc_cmd(logic [4:0] step);
      cmd_type    c;
      logic [4:0] shift;
      c       = '0;
      shift   = 5'(DIV_FIRST + 7) - step;
      unique case (step)
         5'd0:    c.op = OP_DEV;
         5'd1:    c.op = OP_AB;
         5'd2:    c.op = OP_SQA;
         5'd3:    c.op = OP_SQB;
         5'd4:    c.op = OP_DAB;
         5'd5:    c.op = OP_DQA;
         5'd6:    c.op = OP_DQB;
         5'd7:    c.op = OP_P1;
         5'd8:    c.op = OP_P2E;
         5'd9:    c.op = OP_P2;
         5'd10:   c.op = OP_P3;
         5'd11:   c.op = OP_P4;
         5'd12:   c.op = OP_DENLO;
         5'd13:   c.op = OP_DENHI;
         5'd14:   c.op = OP_CRLO;
         5'd15:   c.op = OP_CRHI;
         5'd16:   c.op = OP_NUM;
         5'd17:   c.op = OP_SCALE;
         default: begin
            c.op        = OP_DIV;
            c.div_shift = shift[2:0];
         end
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ipqm_datapath.sv =====
// Datapath: counters, line store, window sums, shared multiplier and quotient unit.
`default_nettype none
module ipqm_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [0:0]                 csr_index,
   input  wire logic [ipqm_pkg::CFG_W-1:0] csr_wdata,
   input  wire logic [15:0]                req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [55:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,
   input  wire ipqm_pkg::cmd_type          cmd,
   output ipqm_pkg::status_type            status
);
   import ipqm_pkg::*;

   logic [CFG_W-1:0]  frame_width_ff, frame_width_in;
   logic [CFG_W-1:0]  frame_height_ff, frame_height_in;
   logic [COL_W-1:0]  col_ff, col_in, base_col_ff, base_col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in, base_slot_ff, base_slot_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [7:0]        ae_ff, ae_in;
   logic              fend_ff, fend_in, win_ok_ff, win_ok_in;

   logic [15:0]       line_mem [0:LINE_DEPTH-1];
   logic [15:0]       rd_data_ff;
   logic              rd_valid_ff, rd_centre_ff;

   logic [SUM_W-1:0]  sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [7:0]        cen_a_ff, cen_a_in, cen_b_ff, cen_b_in;
   logic [SUM_W-1:0]  dev_a_ff, dev_a_in, dev_b_ff, dev_b_in;
   logic              dev_neg_ff, dev_neg_in;
   logic [25:0]       prod_ab_ff, prod_ab_in, dev_prod_ff, dev_prod_in;
   logic [26:0]       sq_sum_ff, sq_sum_in, dev_sq_ff, dev_sq_in;
   logic [34:0]       p1_ff, p1_in, p2_mag_ff, p2_mag_in, p3_ff, p3_in, p4_ff, p4_in;
   logic              p2_neg_ff, p2_neg_in;
   logic [69:0]       den_ff, den_in;
   logic [70:0]       cross_ff, cross_in;
   logic [78:0]       rem_ff, rem_in;
   logic [7:0]        quot_ff, quot_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [55:0]       rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in, rsp_user_ff, rsp_user_in;

   logic [CFG_W-1:0]  w_eff, h_eff;
   logic              col_last, row_last, window_now;
   logic [7:0]        pix_a, pix_b, ae_now;
   logic [15:0]       ae_sq;
   logic [3:0]        slot_sum;
   logic [SLOT_W-1:0] rd_slot;
   logic [COL_W-1:0]  rd_col;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [17:0]       mul_x;
   logic [35:0]       mul_y;
   logic [53:0]       mul_p;
   logic [13:0]       ca25, cb25, sa_ext, sb_ext;
   logic [78:0]       div_trial;

   assign pix_a  = req_tdata[7:0];
   assign pix_b  = req_tdata[15:8];
   assign ae_now = (pix_a > pix_b) ? (pix_a - pix_b) : (pix_b - pix_a);
   assign ae_sq  = ae_now * ae_now;

   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = 10'd1;
      end else if (frame_width_ff > 10'(MAX_WIDTH)) begin
         w_eff = 10'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      h_eff = (frame_height_ff == '0) ? 10'd1 : frame_height_ff;
   end

   assign col_last   = ({1'b0, col_ff} + 10'd1) >= w_eff;
   assign row_last   = ({1'b0, row_ff} + 11'd1) >= {1'b0, h_eff};
   assign window_now = (row_ff >= 10'(WIN_SIZE - 1)) && (col_ff >= 9'(WIN_SIZE - 1));

   // window tap address: row slot k lines back, column m back
   assign slot_sum = {1'b0, base_slot_ff} + 4'(WIN_SIZE) - {1'b0, cmd.win_row};
   assign rd_slot  = (slot_sum >= 4'(WIN_SIZE)) ? 3'(slot_sum - 4'(WIN_SIZE)) : slot_sum[2:0];
   assign rd_col   = base_col_ff - {6'd0, cmd.win_col};
   assign rd_addr  = {rd_slot, rd_col};
   assign wr_addr  = {slot_ff, col_ff};

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (cmd.op)
         OP_AB:    begin mul_x = 18'(sum_a_ff); mul_y = 36'(sum_b_ff); end
         OP_SQA:   begin mul_x = 18'(sum_a_ff); mul_y = 36'(sum_a_ff); end
         OP_SQB:   begin mul_x = 18'(sum_b_ff); mul_y = 36'(sum_b_ff); end
         OP_DAB:   begin mul_x = 18'(dev_a_ff); mul_y = 36'(dev_b_ff); end
         OP_DQA:   begin mul_x = 18'(dev_a_ff); mul_y = 36'(dev_a_ff); end
         OP_DQB:   begin mul_x = 18'(dev_b_ff); mul_y = 36'(dev_b_ff); end
         OP_P1:    begin mul_x = 18'd800; mul_y = 36'(prod_ab_ff); end
         OP_P2E:   begin mul_x = 18'd800; mul_y = 36'(dev_prod_ff); end
         OP_P3:    begin mul_x = 18'd400; mul_y = 36'(sq_sum_ff); end
         OP_P4:    begin mul_x = 18'd400; mul_y = 36'(dev_sq_ff); end
         OP_DENLO: begin mul_x = p3_ff[17:0]; mul_y = 36'(p4_ff); end
         OP_DENHI: begin mul_x = {1'b0, p3_ff[34:18]}; mul_y = 36'(p4_ff); end
         OP_CRLO:  begin mul_x = p1_ff[17:0]; mul_y = 36'(p2_mag_ff); end
         OP_CRHI:  begin mul_x = {1'b0, p1_ff[34:18]}; mul_y = 36'(p2_mag_ff); end
         default:  ;
      endcase
   end

   assign mul_p     = mul_x * mul_y;
   assign ca25      = {cen_a_ff, 4'd0} + {1'b0, cen_a_ff, 3'd0} + {6'd0, cen_a_ff};
   assign cb25      = {cen_b_ff, 4'd0} + {1'b0, cen_b_ff, 3'd0} + {6'd0, cen_b_ff};
   assign sa_ext    = {1'b0, sum_a_ff};
   assign sb_ext    = {1'b0, sum_b_ff};
   assign div_trial = {8'd0, den_ff, 1'b0} << cmd.div_shift;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      slot_in      = slot_ff;
      base_col_in  = base_col_ff;
      base_slot_in = base_slot_ff;
      acc_in       = acc_ff;
      ae_in        = ae_ff;
      fend_in      = fend_ff;
      win_ok_in    = win_ok_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      cen_a_in     = cen_a_ff;
      cen_b_in     = cen_b_ff;
      dev_a_in     = dev_a_ff;
      dev_b_in     = dev_b_ff;
      dev_neg_in   = dev_neg_ff;
      prod_ab_in   = prod_ab_ff;
      dev_prod_in  = dev_prod_ff;
      sq_sum_in    = sq_sum_ff;
      dev_sq_in    = dev_sq_ff;
      p1_in        = p1_ff;
      p2_mag_in    = p2_mag_ff;
      p2_neg_in    = p2_neg_ff;
      p3_in        = p3_ff;
      p4_in        = p4_ff;
      den_in       = den_ff;
      cross_in     = cross_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
         endcase
      end

      // accumulate the tap read in the previous cycle
      if (rd_valid_ff) begin
         sum_a_in = sum_a_ff + {5'd0, rd_data_ff[15:8]};
         sum_b_in = sum_b_ff + {5'd0, rd_data_ff[7:0]};
         if (rd_centre_ff) begin
            cen_a_in = rd_data_ff[15:8];
            cen_b_in = rd_data_ff[7:0];
         end
      end

      unique case (cmd.op)
         OP_ACCEPT: begin
            ae_in        = ae_now;
            acc_in       = (col_ff == '0 && row_ff == '0) ? {18'd0, ae_sq}
                                                          : acc_ff + {18'd0, ae_sq};
            base_col_in  = col_ff;
            base_slot_in = slot_ff;
            win_ok_in    = window_now;
            sum_a_in     = '0;
            sum_b_in     = '0;
            fend_in      = 1'b0;
            if (col_last) begin
               col_in = '0;
               if (row_last) begin
                  row_in  = '0;
                  slot_in = '0;
                  fend_in = 1'b1;
               end else begin
                  row_in  = row_ff + 10'd1;
                  slot_in = (slot_ff == 3'(WIN_SIZE - 1)) ? 3'd0 : slot_ff + 3'd1;
               end
            end else begin
               col_in = col_ff + 9'd1;
            end
         end
         OP_DEV: begin
            dev_a_in   = (ca25 >= sa_ext) ? 13'(ca25 - sa_ext) : 13'(sa_ext - ca25);
            dev_b_in   = (cb25 >= sb_ext) ? 13'(cb25 - sb_ext) : 13'(sb_ext - cb25);
            dev_neg_in = (ca25 < sa_ext) ^ (cb25 < sb_ext);
         end
         OP_AB:    prod_ab_in  = mul_p[25:0];
         OP_SQA:   sq_sum_in   = {1'b0, mul_p[25:0]};
         OP_SQB:   sq_sum_in   = sq_sum_ff + {1'b0, mul_p[25:0]};
         OP_DAB:   dev_prod_in = mul_p[25:0];
         OP_DQA:   dev_sq_in   = {1'b0, mul_p[25:0]};
         OP_DQB:   dev_sq_in   = dev_sq_ff + {1'b0, mul_p[25:0]};
         OP_P1:    p1_in       = mul_p[34:0] + 35'(C1_TERM);
         OP_P2E:   p2_mag_in   = mul_p[34:0];
         OP_P2: begin
            if (!dev_neg_ff) begin
               p2_mag_in = p2_mag_ff + 35'(C2_TERM);
               p2_neg_in = 1'b0;
            end else if (p2_mag_ff > 35'(C2_TERM)) begin
               p2_mag_in = p2_mag_ff - 35'(C2_TERM);
               p2_neg_in = 1'b1;
            end else begin
               p2_mag_in = 35'(C2_TERM) - p2_mag_ff;
               p2_neg_in = 1'b0;
            end
         end
         OP_P3:    p3_in    = mul_p[34:0] + 35'(C1_TERM);
         OP_P4:    p4_in    = mul_p[34:0] + 35'(C2_TERM);
         OP_DENLO: den_in   = {16'd0, mul_p};
         OP_DENHI: den_in   = den_ff + {mul_p[51:0], 18'd0};
         OP_CRLO:  cross_in = {17'd0, mul_p};
         OP_CRHI:  cross_in = cross_ff + {1'b0, mul_p[51:0], 18'd0};
         OP_NUM: begin
            // clamp a negative numerator to zero
            if (!p2_neg_ff) begin
               cross_in = {1'b0, den_ff} + cross_ff;
            end else if ({1'b0, den_ff} >= cross_ff) begin
               cross_in = {1'b0, den_ff} - cross_ff;
            end else begin
               cross_in = '0;
            end
         end
         OP_SCALE: begin
            rem_in  = {cross_ff, 8'd0} - {8'd0, cross_ff};
            quot_in = '0;
         end
         OP_DIV: begin
            if (rem_ff >= div_trial) begin
               rem_in                 = rem_ff - div_trial;
               quot_in[cmd.div_shift] = 1'b1;
            end
         end
         OP_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {6'd0, (win_ok_ff ? quot_ff : 8'd0), acc_ff, ae_ff};
            rsp_last_in  = fend_ff;
            rsp_user_in  = win_ok_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         line_mem[wr_addr] <= {pix_a, pix_b};
      end
      rd_data_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= 10'(MAX_WIDTH);
         frame_height_ff <= 10'(MAX_WIDTH);
         col_ff          <= '0;
         row_ff          <= '0;
         slot_ff         <= '0;
         acc_ff          <= '0;
         rd_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         slot_ff         <= slot_in;
         acc_ff          <= acc_in;
         rd_valid_ff     <= (cmd.op == OP_READ);
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_centre_ff <= (cmd.win_row == 3'(WIN_CENTRE)) && (cmd.win_col == 3'(WIN_CENTRE));
      base_col_ff  <= base_col_in;
      base_slot_ff <= base_slot_in;
      ae_ff        <= ae_in;
      fend_ff      <= fend_in;
      win_ok_ff    <= win_ok_in;
      sum_a_ff     <= sum_a_in;
      sum_b_ff     <= sum_b_in;
      cen_a_ff     <= cen_a_in;
      cen_b_ff     <= cen_b_in;
      dev_a_ff     <= dev_a_in;
      dev_b_ff     <= dev_b_in;
      dev_neg_ff   <= dev_neg_in;
      prod_ab_ff   <= prod_ab_in;
      dev_prod_ff  <= dev_prod_in;
      sq_sum_ff    <= sq_sum_in;
      dev_sq_ff    <= dev_sq_in;
      p1_ff        <= p1_in;
      p2_mag_ff    <= p2_mag_in;
      p2_neg_ff    <= p2_neg_in;
      p3_ff        <= p3_in;
      p4_ff        <= p4_in;
      den_ff       <= den_in;
      cross_ff     <= cross_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;
   assign rsp_tlast        = rsp_last_ff;
   assign rsp_tuser        = rsp_user_ff;
   assign status.window_ok = window_now;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule
`default_nettype wire

// ===== hw/rtl/ipqm_controller.sv =====
// Controller: sequences the accept, window scan, calculation steps and result load.
`default_nettype none
module ipqm_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire ipqm_pkg::status_type status,
   output ipqm_pkg::cmd_type         cmd
);
   import ipqm_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [4:0]       step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op = OP_ACCEPT;
               row_in = '0;
               col_in = '0;
               state_in = status.window_ok ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.op      = OP_READ;
            cmd.win_row = row_ff;
            cmd.win_col = col_ff;
            if (col_ff == 3'(WIN_SIZE - 1)) begin
               col_in = '0;
               row_in = row_ff + 3'd1;
               if (row_ff == 3'(WIN_SIZE - 1)) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in = col_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            step_in  = '0;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd     = calc_cmd(step_ff);
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CALC_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.op   = OP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         step_ff  <= step_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/image_pair_quality_map.sv =====
// Top level of the image pair quality map: controller and datapath.
// Sequence: a border pixel goes from the accept straight to the result load; a pixel
// with a full 5x5 window passes through 25 line store reads, drain, 26 steps and load.
// One pair at a time: the load waits until the output register is free, and the
// next transfer is taken once the result is in the output register.
// Reset (synchronous): counters, error sum and handshakes clear; both frame
// sizes return to 512. The line store is not cleared.
`default_nettype none
module image_pair_quality_map (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [0:0]                 csr_index,
   input  wire logic [ipqm_pkg::CFG_W-1:0] csr_wdata,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,  // ref_pixel[7:0], test_pixel[15:8]
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [55:0]                     rsp_tdata,  // abs_error[7:0],
                                                       // squared_error_sum[41:8],
                                                       // ssim_pixel[49:42]
   output logic                            rsp_tlast,  // frame_end
   output logic                            rsp_tuser   // ssim_valid
);
   import ipqm_pkg::*;

   cmd_type    cmd;
   status_type status;

   ipqm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ipqm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/ipqm_checker.sv =====
// Port checker for the image pair quality map and its bind.
`default_nettype none
module ipqm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[49:42] == 8'd0)
      else $error("border result carries a nonzero index");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a pixel is in progress");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind image_pair_quality_map ipqm_checker u_checker (.*);
`default_nettype wire

// ===== tb/tb_image_pair_quality_map.sv =====
// Self-checking testbench for the image pair quality map: directed frame, then random frames.
`default_nettype none
module tb_image_pair_quality_map;
   import ipqm_pkg::*;

   typedef struct {
      logic [7:0]  abs_err;
      logic [33:0] sq_sum;
      logic        frame_end;
      logic        win_valid;
      logic [7:0]  quality;
   } pixel_result_type;

   typedef struct {
      logic [7:0] ref_px;
      logic [7:0] test_px;
      int         typed_abs;   // -1: take the predicted value
   } pair_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [9:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   image_pair_quality_map uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   // Mirror of the block state
   logic [15:0]      pair_lines [0:4][0:511];
   int unsigned      col_pos;
   int unsigned      row_pos;
   logic [33:0]      err_total;
   logic [9:0]       width_reg;
   logic [9:0]       height_reg;
   pixel_result_type pending_results [$];

   int  mismatches = 0;
   int  stall_cycles;
   bit  calm;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] quality_index(longint sa, longint sb, longint ca, longint cb);
      longint da, db;
      logic signed [127:0] p1, p2, p3, p4, den, num, lim, cand;
      logic [7:0] q;
      da  = 25 * ca - sa;
      db  = 25 * cb - sb;
      p1  = 800 * sa * sb + 1625625;
      p2  = 800 * da * db + 14630625;
      p3  = 400 * (sa * sa + sb * sb) + 1625625;
      p4  = 400 * (da * da + db * db) + 14630625;
      den = p3 * p4;
      if (p2 >= 0) begin
         num = p1 * p2 + den;
      end else begin
         num = den - p1 * (-p2);
         if (num < 0) num = 0;
      end
      lim = num * 255;
      q   = 8'd0;
      for (int b = 7; b >= 0; b--) begin
         cand = 128'(q | (8'd1 << b));
         if (den * 2 * cand <= lim) q = q | (8'd1 << b);
      end
      return q;
   endfunction

   function automatic pixel_result_type predict_pixel(logic [7:0] rp, logic [7:0] tp);
      pixel_result_type res;
      int unsigned      w, h, slot;
      longint           sa, sb;
      logic [15:0]      v, cen;
      logic [7:0]       ae;
      w  = (width_reg == 0) ? 1 : (width_reg > 512) ? 512 : width_reg;
      h  = (height_reg == 0) ? 1 : height_reg;
      ae = (rp > tp) ? rp - tp : tp - rp;
      if (col_pos == 0 && row_pos == 0) err_total = 34'(ae) * 34'(ae);
      else err_total = err_total + 34'(ae) * 34'(ae);
      if (col_pos < 512) pair_lines[row_pos % 5][col_pos] = {rp, tp};
      res.abs_err   = ae;
      res.sq_sum    = err_total;
      res.frame_end = 1'b0;
      res.win_valid = 1'b0;
      res.quality   = 8'd0;
      if (row_pos >= 4 && col_pos >= 4 && col_pos < 512) begin
         sa = 0;
         sb = 0;
         for (int k = 0; k < 5; k++) begin
            slot = (row_pos - k) % 5;
            for (int m = 0; m < 5; m++) begin
               v  = pair_lines[slot][col_pos - m];
               sa += v[15:8];
               sb += v[7:0];
            end
         end
         cen           = pair_lines[(row_pos - 2) % 5][col_pos - 2];
         res.win_valid = 1'b1;
         res.quality   = quality_index(sa, sb, cen[15:8], cen[7:0]);
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         if (row_pos + 1 >= h) begin
            row_pos       = 0;
            res.frame_end = 1'b1;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   task automatic send_pair(logic [7:0] rp, logic [7:0] tp, int typed_abs);
      int gap;
      pixel_result_type res;
      gap = 0;
      while (!calm && $urandom_range(99) < 34) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {tp, rp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = predict_pixel(rp, tp);
      if (typed_abs >= 0) res.abs_err = typed_abs[7:0];
      pending_results.push_back(res);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_frame(logic [9:0] w, logic [9:0] h);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_FRAME_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we     <= 1'b0;
      width_reg  = w;
      height_reg = h;
   endtask

   task automatic random_frame(int unsigned pixels, int mode, bit pause_midway);
      logic [7:0] rp, tp;
      int         noise;
      for (int i = 0; i < pixels; i++) begin
         if (pause_midway && i == pixels / 2) drain();
         rp = $urandom_range(255);
         case (mode)
            0: tp = $urandom_range(255);
            1: begin
               noise = int'(rp) + $urandom_range(8) - 4;
               tp    = (noise < 0) ? 8'd0 : (noise > 255) ? 8'd255 : noise[7:0];
            end
            default: begin
               rp = $urandom_range(1) ? 8'd255 : 8'd0;
               tp = $urandom_range(3) == 0 ? ~rp : rp;
            end
         endcase
         send_pair(rp, tp, -1);
      end
   endtask

   // Response side: random backpressure, check each transfer, watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready   <= 1'b0;
         stall_cycles <= 0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 34);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles > 5000) begin
            $display("CHECK FAILED");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transfer %h", rsp_tdata);
            end else begin
               pixel_result_type e;
               e = pending_results.pop_front();
               if (rsp_tdata[7:0] !== e.abs_err || rsp_tdata[41:8] !== e.sq_sum ||
                   rsp_tdata[49:42] !== e.quality || rsp_tlast !== e.frame_end ||
                   rsp_tuser !== e.win_valid) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp ae=%0d sum=%0d q=%0d last=%b valid=%b,",
                               " got ae=%0d sum=%0d q=%0d last=%b valid=%b"},
                        e.abs_err, e.sq_sum, e.quality, e.frame_end, e.win_valid,
                        rsp_tdata[7:0], rsp_tdata[41:8], rsp_tdata[49:42], rsp_tlast,
                        rsp_tuser);
               end
            end
         end
      end
   end

   pair_row_type directed_rows [25] = '{
      '{8'd0,   8'd255, 255}, '{8'd255, 8'd0,   255}, '{8'd0,   8'd0,   0},
      '{8'd255, 8'd255, 0},   '{8'd128, 8'd127, 1},   '{8'd1,   8'd2,   1},
      '{8'd170, 8'd85,  85},  '{8'd85,  8'd170, 85},  '{8'd255, 8'd254, 1},
      '{8'd254, 8'd255, 1},   '{8'd10,  8'd200, -1},  '{8'd33,  8'd31,  -1},
      '{8'd0,   8'd255, 255}, '{8'd77,  8'd77,  0},   '{8'd240, 8'd15,  -1},
      '{8'd15,  8'd240, -1},  '{8'd255, 8'd0,   255}, '{8'd100, 8'd90,  -1},
      '{8'd60,  8'd61,  -1},  '{8'd200, 8'd199, -1},  '{8'd255, 8'd255, 0},
      '{8'd0,   8'd0,   0},   '{8'd129, 8'd126, -1},  '{8'd64,  8'd192, -1},
      '{8'd192, 8'd64,  -1}
   };

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = CSR_FRAME_WIDTH;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      calm       = 1'b0;
      col_pos    = 0;
      row_pos    = 0;
      err_total  = '0;
      width_reg  = 10'd512;
      height_reg = 10'd512;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one 5x5 frame: only the last pixel has a full window
      set_frame(10'd5, 10'd5);
      foreach (directed_rows[i])
         send_pair(directed_rows[i].ref_px, directed_rows[i].test_px,
                   directed_rows[i].typed_abs);

      for (int f = 0; f < 4; f++) random_frame(25, f % 3, f == 1);
      set_frame(10'd0, 10'd0);                  // zero size acts as one pixel
      random_frame(8, 0, 1'b0);
      set_frame(10'd3, 10'd9);                  // too narrow for any window
      random_frame(54, 0, 1'b0);
      set_frame(10'd12, 10'd8);
      calm = 1'b1;
      random_frame(96, 1, 1'b0);
      calm = 1'b0;
      for (int f = 0; f < 3; f++) random_frame(96, (f + 1) % 3, f == 0);
      set_frame(10'd1023, 10'd1);               // width clamps to 512
      random_frame(512, 0, 1'b0);
      set_frame(10'd1, 10'd512);
      random_frame(512, 2, 1'b0);

      drain();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
